@@ rtl/icr_pkg.sv @@
// Shared constants and types for the integer cube root block.
package icr_pkg;

   localparam int ROOT_WIDTH = 21;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

@@ rtl/icr_if.sv @@
// Valid/ready channel interfaces for the radicand requests and the root responses.
interface icr_req_if #(
   parameter int RADICAND_WIDTH = 63
);
   logic                      valid;
   logic                      ready;
   logic [RADICAND_WIDTH-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

interface icr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [icr_pkg::ROOT_WIDTH-1:0]  root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

@@ rtl/integer_cube_root_floor.sv @@
// Floor cube root of an unsigned integer, one root bit found per clock cycle.
//
// Each transfer on the request channel carries one radicand; the block answers with exactly
// one response holding the greatest root whose cube does not exceed it, truncated to 21 bits.
// The radicand is consumed three bits per cycle by a digit-by-digit restoring recurrence that
// keeps the partial root, its square and the running remainder, so one shared add-and-compare
// unit does all the work. An item is loaded in ST_IDLE, worked on in ST_RUN and presented in
// ST_DONE until the response is taken. The block takes a new request only after the previous
// response has been transferred.
module integer_cube_root_floor #(
   parameter int RADICAND_WIDTH = 63
) (
   input  logic      clock,
   input  logic      reset,
   icr_req_if.sink   req_if,
   icr_rsp_if.source rsp_if
);

   localparam int NUM_DIGITS = (RADICAND_WIDTH + 2) / 3;
   localparam int RT_W       = NUM_DIGITS;
   localparam int SQ_W       = 2 * RT_W;
   localparam int REM_W      = 2 * RT_W + 5;
   localparam int PAD_W      = 3 * NUM_DIGITS;
   localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
   localparam int EXT_W      = (RT_W > icr_pkg::ROOT_WIDTH) ? RT_W : icr_pkg::ROOT_WIDTH;

   icr_pkg::state_type state_ff, state_in;

   logic [PAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             load;
   logic             step;
   logic             last_step;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             keep;
   logic [EXT_W-1:0] root_ext;

   assign last_step = (cnt_ff == CNT_W'(NUM_DIGITS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         icr_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               state_in = icr_pkg::ST_RUN;
            end
         end
         icr_pkg::ST_RUN: begin
            if (last_step) begin
               state_in = icr_pkg::ST_DONE;
            end
         end
         icr_pkg::ST_DONE: begin
            if (rsp_if.ready) begin
               state_in = icr_pkg::ST_IDLE;
            end
         end
         default: state_in = icr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;
      step         = 1'b0;
      unique case (state_ff)
         icr_pkg::ST_IDLE: req_if.ready = 1'b1;
         icr_pkg::ST_RUN:  step         = 1'b1;
         icr_pkg::ST_DONE: rsp_if.valid = 1'b1;
         default: ;
      endcase
   end

   assign load = req_if.valid && req_if.ready;

   always_comb begin
      rem_sh = REM_W'({rem_ff, rad_ff[PAD_W-1 -: 3]});
      trial  = REM_W'({sq_ff, 3'b000}) + REM_W'({sq_ff, 2'b00})
             + REM_W'({root_ff, 2'b00}) + REM_W'({root_ff, 1'b0}) + REM_W'(1);
      keep   = (rem_sh >= trial);

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      sq_in   = sq_ff;
      cnt_in  = cnt_ff;

      if (load) begin
         rad_in  = PAD_W'(req_if.radicand);
         rem_in  = '0;
         root_in = '0;
         sq_in   = '0;
         cnt_in  = '0;
      end else if (step) begin
         rad_in = PAD_W'({rad_ff, 3'b000});
         cnt_in = cnt_ff + CNT_W'(1);
         if (keep) begin
            rem_in  = rem_sh - trial;
            root_in = RT_W'({root_ff, 1'b1});
            sq_in   = SQ_W'({sq_ff, 2'b00}) + SQ_W'({root_ff, 2'b00}) + SQ_W'(1);
         end else begin
            rem_in  = rem_sh;
            root_in = RT_W'({root_ff, 1'b0});
            sq_in   = SQ_W'({sq_ff, 2'b00});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icr_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      sq_ff   <= sq_in;
   end

   assign root_ext    = EXT_W'(root_ff);
   assign rsp_if.root = root_ext[icr_pkg::ROOT_WIDTH-1:0];

endmodule
